// ===== hw/rtl/gsfr_pkg.sv =====
// Shared types and constants for the gas sensor frame receiver.
package gsfr_pkg;

  localparam int unsigned FrameBytes = 9;
  localparam int unsigned PosW       = 4;
  localparam logic [PosW-1:0] LastPos   = PosW'(FrameBytes - 1);  // checksum byte
  localparam logic [PosW-1:0] GasPos    = PosW'(1);
  localparam logic [PosW-1:0] ConcHiPos = PosW'(4);
  localparam logic [PosW-1:0] ConcLoPos = PosW'(5);

  localparam logic [15:0] ByteTimerMax  = 16'hFFFF;
  localparam logic [23:0] ValidTimerMax = 24'hFF_FFFF;

  localparam logic [7:0]  StartByteRst      = 8'hFF;
  localparam logic [7:0]  TargetGasIdRst    = 8'h00;
  localparam logic [15:0] InterbyteLimitRst = 16'd1000;
  localparam logic [23:0] CommTimeoutRst    = 24'd10000;

  typedef enum logic [1:0] {
    CFG_START_BYTE      = 2'd0,
    CFG_TARGET_GAS_ID   = 2'd1,
    CFG_INTERBYTE_LIMIT = 2'd2,
    CFG_COMM_TIMEOUT    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  target_gas_id;
    logic [15:0] interbyte_limit;
    logic [23:0] comm_timeout;
  } cfg_t;

  typedef struct packed {
    logic        reading_valid;
    logic [15:0] concentration;
    logic        online;
    logic        checksum_error;
    logic        lost_frame;
    logic        comm_timeout_event;
    logic [31:0] crc_error_count;
    logic [31:0] lost_frame_count;
    logic [31:0] timeout_count;
  } result_t;

endpackage

// ===== hw/rtl/gsfr_cfg_regs.sv =====
// Configuration register file for the gas sensor frame receiver.
module gsfr_cfg_regs import gsfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output logic        cfg_ready_o,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte      <= StartByteRst;
      cfg_q.target_gas_id   <= TargetGasIdRst;
      cfg_q.interbyte_limit <= InterbyteLimitRst;
      cfg_q.comm_timeout    <= CommTimeoutRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_BYTE:      cfg_q.start_byte      <= cfg_data_i[7:0];
        CFG_TARGET_GAS_ID:   cfg_q.target_gas_id   <= cfg_data_i[7:0];
        CFG_INTERBYTE_LIMIT: cfg_q.interbyte_limit <= cfg_data_i[15:0];
        CFG_COMM_TIMEOUT:    cfg_q.comm_timeout    <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gsfr_in_reg.sv =====
// Input item register with stall back-pressure.
module gsfr_in_reg import gsfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  input  logic       advance_i,   // downstream can take the held item
  output logic       item_valid_o,
  output func_e      item_func_o,
  output logic [7:0] item_byte_o
);

  logic       valid_q;
  func_e      func_q;
  logic [7:0] byte_q;
  logic       load;

  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      func_q <= func_e'(func_i);
      byte_q <= data_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_func_o  = func_q;
  assign item_byte_o  = byte_q;

endmodule

// ===== hw/rtl/gsfr_core.sv =====
// Frame assembly, checksum, timers and counters for one item per cycle while fire_i is high.
module gsfr_core import gsfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       fire_i,
  input  func_e      func_i,
  input  logic [7:0] byte_i,
  output result_t    result_o
);

  // control state
  logic [PosW-1:0] pos_q, pos_d;
  logic            online_q, online_d;
  logic            latched_q, latched_d;
  logic [15:0]     tsb_q, tsb_d;
  logic [23:0]     tsv_q, tsv_d;
  logic [31:0]     crc_q, crc_d;
  logic [31:0]     lost_q, lost_d;
  logic [31:0]     to_q, to_d;
  // frame payload, written by each frame before use
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      gas_q, gas_d;
  logic [7:0]      hi_q, hi_d;
  logic [7:0]      lo_q, lo_d;

  logic        rd_f, crc_f, lost_f, to_f;
  logic [15:0] conc;
  logic [15:0] tsb_inc;
  logic [23:0] tsv_inc;

  assign tsb_inc = (tsb_q == ByteTimerMax)  ? tsb_q : tsb_q + 16'd1;
  assign tsv_inc = (tsv_q == ValidTimerMax) ? tsv_q : tsv_q + 24'd1;

  always_comb begin
    pos_d     = pos_q;
    online_d  = online_q;
    latched_d = latched_q;
    tsb_d     = tsb_q;
    tsv_d     = tsv_q;
    sum_d     = sum_q;
    gas_d     = gas_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    rd_f      = 1'b0;
    crc_f     = 1'b0;
    lost_f    = 1'b0;
    to_f      = 1'b0;
    conc      = 16'd0;

    unique case (func_i)
      FUNC_BYTE: begin
        tsb_d = 16'd0;
        if (pos_q == '0) begin
          if (byte_i == cfg_i.start_byte) begin
            pos_d = PosW'(1);
            sum_d = 8'd0;
          end
        end else if (byte_i == cfg_i.start_byte) begin
          // resync: partial frame is lost
          lost_f = 1'b1;
          pos_d  = PosW'(1);
          sum_d  = 8'd0;
        end else if (pos_q < LastPos) begin
          sum_d = sum_q + byte_i;
          if (pos_q == GasPos)    gas_d = byte_i;
          if (pos_q == ConcHiPos) hi_d  = byte_i;
          if (pos_q == ConcLoPos) lo_d  = byte_i;
          pos_d = pos_q + PosW'(1);
        end else begin
          pos_d = '0;
          if (sum_q != byte_i) begin
            crc_f = 1'b1;
          end else begin
            tsv_d     = 24'd0;
            latched_d = 1'b0;
            online_d  = 1'b1;
            if (gas_q == cfg_i.target_gas_id) begin
              rd_f = 1'b1;
              conc = {hi_q, lo_q};
            end else begin
              lost_f = 1'b1;
            end
          end
        end
      end
      FUNC_TICK: begin
        tsb_d = tsb_inc;
        tsv_d = tsv_inc;
        if (pos_q != '0 && tsb_inc > cfg_i.interbyte_limit) begin
          lost_f = 1'b1;
          pos_d  = '0;
        end
        if (!latched_q && tsv_inc > cfg_i.comm_timeout) begin
          to_f      = 1'b1;
          latched_d = 1'b1;
          online_d  = 1'b0;
        end
      end
      default: ;
    endcase

    crc_d  = crc_q  + {31'd0, crc_f};
    lost_d = lost_q + {31'd0, lost_f};
    to_d   = to_q   + {31'd0, to_f};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      online_q  <= 1'b0;
      latched_q <= 1'b0;
      tsb_q     <= '0;
      tsv_q     <= '0;
      crc_q     <= '0;
      lost_q    <= '0;
      to_q      <= '0;
    end else if (fire_i) begin
      pos_q     <= pos_d;
      online_q  <= online_d;
      latched_q <= latched_d;
      tsb_q     <= tsb_d;
      tsv_q     <= tsv_d;
      crc_q     <= crc_d;
      lost_q    <= lost_d;
      to_q      <= to_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      sum_q <= sum_d;
      gas_q <= gas_d;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
    end
  end

  always_comb begin
    result_o.reading_valid      = rd_f;
    result_o.concentration      = conc;
    result_o.online             = online_d;
    result_o.checksum_error     = crc_f;
    result_o.lost_frame         = lost_f;
    result_o.comm_timeout_event = to_f;
    result_o.crc_error_count    = crc_d;
    result_o.lost_frame_count   = lost_d;
    result_o.timeout_count      = to_d;
  end

endmodule

// ===== hw/rtl/gsfr_out_reg.sv =====
// Result register toward the output channel.
module gsfr_out_reg import gsfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    advance_o,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    valid_q;
  result_t res_q;

  // register is free when empty or its result is taken this cycle
  assign advance_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && item_valid_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

// ===== hw/rtl/gas_sensor_frame_receiver.sv =====
// Top level of the gas sensor frame receiver.
// Gas sensor frame receiver. Each input transfer carries either a received
// UART byte (func 0) or a one-millisecond tick (func 1) and yields exactly one
// result transfer. Bytes are assembled into 9-byte frames that open with
// start_byte; the ninth byte must equal the low byte of the sum of bytes 1..7.
// A good frame puts the link online and restarts the validity timer; if its
// gas id (byte 1) matches target_gas_id the big-endian concentration from
// bytes 4 and 5 is reported with reading_valid, otherwise a lost frame is
// counted. A start byte inside a frame restarts it and counts a lost frame.
// Ticks advance two saturating timers: a partial frame idle longer than
// interbyte_limit ticks is dropped (lost frame), and once no good frame has
// arrived for more than comm_timeout ticks the link goes offline and the
// timeout counter steps once. All three counters wrap at 32 bits.
// Timing: an accepted item is held in the input register, where the parser
// logic evaluates it; when the output register can advance, state updates and
// the result is loaded into it together, so one item is taken every cycle
// while not stalled. in_stall_o rises only when the output register is full
// and stalled. Configuration writes are always ready (cfg_ready_o = 1) and
// must be issued only while no item is in flight; register index 0 start_byte,
// 1 target_gas_id, 2 interbyte_limit, 3 comm_timeout.
module gas_sensor_frame_receiver import gsfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        reading_valid_o,
  output logic [15:0] concentration_o,
  output logic        online_o,
  output logic        checksum_error_o,
  output logic        lost_frame_o,
  output logic        comm_timeout_event_o,
  output logic [31:0] crc_error_count_o,
  output logic [31:0] lost_frame_count_o,
  output logic [31:0] timeout_count_o
);

  cfg_t       cfg;
  logic       advance;
  logic       item_valid;
  func_e      item_func;
  logic [7:0] item_byte;
  result_t    result;
  result_t    result_q;

  gsfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  gsfr_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_func_o  (item_func),
    .item_byte_o  (item_byte)
  );

  // state commits exactly when the held item moves into the result register
  gsfr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (item_valid & advance),
    .func_i   (item_func),
    .byte_i   (item_byte),
    .result_o (result)
  );

  gsfr_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .result_i     (result),
    .out_stall_i  (out_stall_i),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .result_o     (result_q)
  );

  assign reading_valid_o      = result_q.reading_valid;
  assign concentration_o      = result_q.concentration;
  assign online_o             = result_q.online;
  assign checksum_error_o     = result_q.checksum_error;
  assign lost_frame_o         = result_q.lost_frame;
  assign comm_timeout_event_o = result_q.comm_timeout_event;
  assign crc_error_count_o    = result_q.crc_error_count;
  assign lost_frame_count_o   = result_q.lost_frame_count;
  assign timeout_count_o      = result_q.timeout_count;

endmodule

// ===== tb/gsfr_frame_checker.sv =====
// Result checker for the gas sensor frame receiver: prediction and comparison.
module gsfr_frame_checker import gsfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        reading_valid_i,
  input  logic [15:0] concentration_i,
  input  logic        online_i,
  input  logic        checksum_error_i,
  input  logic        lost_frame_i,
  input  logic        comm_timeout_event_i,
  input  logic [31:0] crc_error_count_i,
  input  logic [31:0] lost_frame_count_i,
  input  logic [31:0] timeout_count_i,
  output int          mismatch_count_o,
  output int          awaiting_o
);

  cfg_t            link_cfg;
  logic [PosW-1:0] frame_pos;
  logic [7:0]      frame_bytes [8];
  logic            link_up;
  logic            timeout_seen;
  logic [15:0]     byte_ticks;
  logic [23:0]     valid_ticks;
  logic [31:0]     crc_total;
  logic [31:0]     lost_total;
  logic [31:0]     timeout_total;

  result_t results_due [$];
  result_t due;
  result_t seen;
  int      mismatches = 0;

  assign seen = {reading_valid_i, concentration_i, online_i, checksum_error_i, lost_frame_i,
                 comm_timeout_event_i, crc_error_count_i, lost_frame_count_i, timeout_count_i};
  assign mismatch_count_o = mismatches;

  // One byte or tick through the frame parser; returns the result it causes.
  function automatic result_t frame_step(func_e kind, logic [7:0] rx);
    result_t    r;
    logic [7:0] sum;
    r = '0;
    if (kind == FUNC_BYTE) begin
      byte_ticks = '0;
      if (frame_pos == '0) begin
        if (rx == link_cfg.start_byte) begin
          frame_bytes[0] = rx;
          frame_pos = PosW'(1);
        end
      end else if (rx == link_cfg.start_byte) begin
        // resync on a start byte inside a frame
        lost_total = lost_total + 32'd1;
        r.lost_frame = 1'b1;
        frame_bytes[0] = rx;
        frame_pos = PosW'(1);
      end else if (frame_pos < LastPos) begin
        frame_bytes[frame_pos[2:0]] = rx;
        frame_pos = frame_pos + PosW'(1);
      end else begin
        sum = '0;
        for (int i = 1; i < 8; i++) sum = sum + frame_bytes[i];
        frame_pos = '0;
        if (sum != rx) begin
          crc_total = crc_total + 32'd1;
          r.checksum_error = 1'b1;
        end else begin
          valid_ticks = '0;
          timeout_seen = 1'b0;
          link_up = 1'b1;
          if (frame_bytes[GasPos[2:0]] == link_cfg.target_gas_id) begin
            r.reading_valid = 1'b1;
            r.concentration = {frame_bytes[ConcHiPos[2:0]], frame_bytes[ConcLoPos[2:0]]};
          end else begin
            lost_total = lost_total + 32'd1;
            r.lost_frame = 1'b1;
          end
        end
      end
    end else begin
      if (byte_ticks != ByteTimerMax) byte_ticks = byte_ticks + 16'd1;
      if (valid_ticks != ValidTimerMax) valid_ticks = valid_ticks + 24'd1;
      if (frame_pos != '0 && byte_ticks > link_cfg.interbyte_limit) begin
        lost_total = lost_total + 32'd1;
        r.lost_frame = 1'b1;
        frame_pos = '0;
      end
      if (!timeout_seen && valid_ticks > link_cfg.comm_timeout) begin
        timeout_total = timeout_total + 32'd1;
        timeout_seen = 1'b1;
        link_up = 1'b0;
        r.comm_timeout_event = 1'b1;
      end
    end
    r.online = link_up;
    r.crc_error_count = crc_total;
    r.lost_frame_count = lost_total;
    r.timeout_count = timeout_total;
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_cfg = '{start_byte: StartByteRst, target_gas_id: TargetGasIdRst,
                   interbyte_limit: InterbyteLimitRst, comm_timeout: CommTimeoutRst};
      frame_pos = '0;
      for (int i = 0; i < 8; i++) frame_bytes[i] = '0;
      link_up = 1'b0;
      timeout_seen = 1'b0;
      byte_ticks = '0;
      valid_ticks = '0;
      crc_total = '0;
      lost_total = '0;
      timeout_total = '0;
      results_due.delete();
      awaiting_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, actual %h", $time, seen);
        end else begin
          due = results_due.pop_front();
          check_field("reading_valid", 32'(due.reading_valid), 32'(seen.reading_valid));
          check_field("concentration", 32'(due.concentration), 32'(seen.concentration));
          check_field("online", 32'(due.online), 32'(seen.online));
          check_field("checksum_error", 32'(due.checksum_error), 32'(seen.checksum_error));
          check_field("lost_frame", 32'(due.lost_frame), 32'(seen.lost_frame));
          check_field("comm_timeout_event", 32'(due.comm_timeout_event),
                      32'(seen.comm_timeout_event));
          check_field("crc_error_count", due.crc_error_count, seen.crc_error_count);
          check_field("lost_frame_count", due.lost_frame_count, seen.lost_frame_count);
          check_field("timeout_count", due.timeout_count, seen.timeout_count);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_START_BYTE:      link_cfg.start_byte = cfg_data_i[7:0];
          CFG_TARGET_GAS_ID:   link_cfg.target_gas_id = cfg_data_i[7:0];
          CFG_INTERBYTE_LIMIT: link_cfg.interbyte_limit = cfg_data_i[15:0];
          CFG_COMM_TIMEOUT:    link_cfg.comm_timeout = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) results_due.push_back(frame_step(func_e'(func_i), data_byte_i));
      awaiting_o <= results_due.size();
    end
  end

endmodule

// ===== tb/tb_gas_sensor_frame_receiver.sv =====
// Testbench top for the gas sensor frame receiver: stimulus, handshakes and verdict.
module tb_gas_sensor_frame_receiver;
  import gsfr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        reading_valid_o;
  logic [15:0] concentration_o;
  logic        online_o;
  logic        checksum_error_o;
  logic        lost_frame_o;
  logic        comm_timeout_event_o;
  logic [31:0] crc_error_count_o;
  logic [31:0] lost_frame_count_o;
  logic [31:0] timeout_count_o;

  int mismatch_count;
  int awaiting;

  // Idle rates in percent, changed per phase by the stimulus process.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  // Local copies of the framing registers, needed to shape well-formed frames.
  logic [7:0] start_sb = StartByteRst;
  logic [7:0] target_gas = TargetGasIdRst;

  always #6 clk_i = ~clk_i;

  gas_sensor_frame_receiver dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .data_byte_i,
    .out_valid_o, .out_stall_i,
    .reading_valid_o, .concentration_o, .online_o, .checksum_error_o, .lost_frame_o,
    .comm_timeout_event_o, .crc_error_count_o, .lost_frame_count_o, .timeout_count_o
  );

  // The checker watches all three channels and keeps its own frame parser.
  gsfr_frame_checker frame_chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .data_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .reading_valid_i(reading_valid_o), .concentration_i(concentration_o),
    .online_i(online_o), .checksum_error_i(checksum_error_o), .lost_frame_i(lost_frame_o),
    .comm_timeout_event_i(comm_timeout_event_o), .crc_error_count_i(crc_error_count_o),
    .lost_frame_count_i(lost_frame_count_o), .timeout_count_i(timeout_count_o),
    .mismatch_count_o(mismatch_count), .awaiting_o(awaiting)
  );

  // Receiver side: stall drawn fresh every cycle, so stalls hit every phase of the pipe.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // One input transfer. Valid stays high after acceptance; the next call either
  // keeps it high with a new payload or drops it while the sender idles.
  task automatic push_item(func_e kind, logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= kind;
    data_byte_i <= rx;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Tick items carry a random byte, which the block must ignore.
  task automatic send_tick();
    push_item(FUNC_TICK, 8'($urandom_range(255)));
  endtask

  // Random byte that cannot be mistaken for a start byte.
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    if (v == start_sb) v = v + 8'd1;
    return v;
  endfunction

  // Full 9-byte frame: start, gas id, two filler bytes, concentration (hi, lo),
  // two filler bytes, checksum. A bad checksum is the good one with bits flipped.
  // Filler is redrawn when the checksum would collide with the start byte.
  task automatic send_frame(logic [7:0] gas, logic [15:0] conc, bit good, int tick_pct);
    logic [7:0] body [8];
    int         tries;
    body[0] = start_sb;
    body[1] = gas;
    body[4] = conc[15:8];
    body[5] = conc[7:0];
    tries = 0;
    do begin
      body[2] = pick_byte();
      body[3] = pick_byte();
      body[6] = pick_byte();
      body[7] = pick_byte();
      body[0] = '0;
      for (int i = 1; i < 8; i++) body[0] = body[0] + body[i];
      if (!good) body[0] = body[0] ^ 8'($urandom_range(1, 255));
      tries++;
    end while (body[0] == start_sb && tries < 16);
    push_item(FUNC_BYTE, start_sb);
    for (int i = 1; i < 8; i++) begin
      // ticks inside a frame let the inter-byte timer run mid-frame
      if ($urandom_range(99) < tick_pct) send_tick();
      push_item(FUNC_BYTE, body[i]);
    end
    if ($urandom_range(99) < tick_pct) send_tick();
    push_item(FUNC_BYTE, body[0]);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off the sender until every expected result has come out, then let the
  // two-stage pipe sit idle before touching registers.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaiting != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Reprogram all four registers while the block is idle. Unused upper data
  // bits of the 8/16-bit registers get random junk to check the masking.
  task automatic program_link(logic [7:0] sb, logic [7:0] gas, logic [15:0] ib_lim,
                              logic [23:0] ct_lim);
    settle();
    write_reg(CFG_START_BYTE, {16'($urandom), sb});
    write_reg(CFG_TARGET_GAS_ID, {16'($urandom), gas});
    write_reg(CFG_INTERBYTE_LIMIT, {8'($urandom), ib_lim});
    write_reg(CFG_COMM_TIMEOUT, ct_lim);
    start_sb = sb;
    target_gas = gas;
  endtask

  // One random episode. Mostly well-formed frames (matching gas id, good checksum)
  // so the parser gets past its first states; the rest is tick bursts, truncated
  // frames and raw noise that also hits the start byte and both item kinds.
  task automatic random_burst();
    int         pick;
    logic [7:0] gas;
    pick = $urandom_range(99);
    if (pick < 55) begin
      gas = ($urandom_range(99) < 70) ? target_gas : pick_byte();
      send_frame(gas, {pick_byte(), pick_byte()}, $urandom_range(99) < 85,
                 ($urandom_range(99) < 20) ? 15 : 0);
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 12)) send_tick();
    end else if (pick < 82) begin
      push_item(FUNC_BYTE, start_sb);
      repeat ($urandom_range(0, 7)) push_item(FUNC_BYTE, pick_byte());
    end else begin
      repeat ($urandom_range(1, 6)) push_item(func_e'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  task automatic random_phase(int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) random_burst();
  endtask

  initial begin
    logic [7:0] sb;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset register values.
    push_item(FUNC_BYTE, 8'h00);                 // stray byte while idle: ignored
    send_frame(8'h00, 16'h0000, 1'b1, 0);        // good frame, target gas: reading
    push_item(FUNC_BYTE, 8'hFF);
    push_item(FUNC_BYTE, 8'h05);
    send_frame(8'h05, 16'h00FE, 1'b0, 0);        // start byte mid-frame, then bad checksum
    send_tick();

    // Zero limits: the first tick drops the partial frame and fires the timeout,
    // the second finds the timeout already latched.
    program_link(8'hFF, 8'h00, 16'd0, 24'd0);
    push_item(FUNC_BYTE, 8'hFF);
    send_tick();
    send_tick();

    // Phase 1: sender idles 23%, receiver 49%; short timers so both fire often.
    sb = 8'($urandom_range(255));
    program_link(sb, sb ^ 8'($urandom_range(1, 255)), 16'($urandom_range(1, 6)),
                 24'($urandom_range(5, 40)));
    send_idle_pct = 23;
    stall_pct = 49;
    random_phase(700);

    // Phase 2: roles swapped; register extremes, timers that can never fire.
    program_link(8'h00, 8'hFF, 16'hFFFF, 24'hFF_FFFF);
    send_idle_pct = 49;
    stall_pct = 23;
    random_phase(650);

    // Phase 3: full rate both ways.
    sb = 8'($urandom_range(255));
    program_link(sb, sb ^ 8'($urandom_range(1, 255)), 16'($urandom_range(1, 3)),
                 24'($urandom_range(1, 20)));
    send_idle_pct = 0;
    stall_pct = 0;
    random_phase(650);

    settle();
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("[gas_sensor_frame_receiver] OK");
    end else begin
      $display("[gas_sensor_frame_receiver] ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #6000000;
    $display("[gas_sensor_frame_receiver] ERROR");
    $finish;
  end

endmodule
